// ===== rtl/core/cadb_pkg.sv =====
// Shared types, constants and arithmetic helpers of the cross-ambiguity Doppler bank.
// Holds the quarter-wave sine table, built at elaboration.
// No dependencies.
package cadb_pkg;

  localparam int MAX_BINS  = 64;
  localparam int BIN_W     = 6;
  localparam int CNT_W     = 7;
  localparam int SIN_BITS  = 10;
  localparam int QUARTER   = 1 << (SIN_BITS - 2);
  localparam int ACC_W     = 48;
  localparam int PH_W      = 32;
  localparam int SMP_W     = 16;
  localparam int PWR_W     = 63;
  localparam int WORD_W    = PH_W + 2 * ACC_W;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] CFG_NUM_BINS   = 2'd0;
  localparam logic [1:0] CFG_MIN_INCR   = 2'd1;
  localparam logic [1:0] CFG_INCR_STEP  = 2'd2;

  typedef logic [SMP_W-2:0] qtab_t [0:QUARTER];

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_DUMP = 5'b00100,
    ST_PWR  = 5'b01000,
    ST_HOLD = 5'b10000
  } state_e;

  function automatic qtab_t gen_qtab();
    qtab_t tab;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned term;
    longint sum;
    for (int k = 0; k <= QUARTER; k++) begin
      t = (longint'(k) * HALF_PI_Q30) >> (SIN_BITS - 2);
      t2 = (t * t) >> 30;
      term = t;
      sum = longint'(t);
      term = ((term * t2) >> 30) / 64'd6;
      sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd20;
      sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd42;
      sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd72;
      sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd110;
      sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 64'd156;
      sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 64'd210;
      sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > 32767) sum = 32767;
      tab[k] = sum[SMP_W-2:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = gen_qtab();

  function automatic logic signed [SMP_W-1:0] sine_lut(input logic [SIN_BITS-1:0] idx);
    logic [SIN_BITS-3:0] r;
    logic [SIN_BITS-2:0] rr;
    logic signed [SMP_W-1:0] v;
    r = idx[SIN_BITS-3:0];
    rr = idx[SIN_BITS-2] ? (SIN_BITS-1)'(QUARTER) - {1'b0, r} : {1'b0, r};
    v = $signed({1'b0, QTAB[rr]});
    return idx[SIN_BITS-1] ? -v : v;
  endfunction

  function automatic logic signed [SMP_W-1:0] rnd_sat16(input logic signed [33:0] x);
    logic signed [34:0] v;
    logic signed [19:0] sh;
    v = 35'(x) + 35'sd16384;
    sh = 20'(v >>> 15);
    if (sh > 20'sd32767) return 16'sh7fff;
    if (sh < -20'sd32768) return 16'sh8000;
    return sh[SMP_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add48(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [32:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W-32){b[32]}}, b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/core/cadb_ram.sv =====
// Generic simple dual-port RAM with one write and one registered read port.
// No dependencies.
module cadb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cadb_pwr.sv =====
// Squared magnitude unit: |re|^2 + |im|^2, shifted right 32, saturated to 63 bits.
// Three register stages; depends on cadb_pkg.
module cadb_pwr import cadb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [ACC_W-1:0]  re_i,
  input  logic signed [ACC_W-1:0]  im_i,
  output logic                     valid_o,
  output logic [PWR_W-1:0]         power_o
);

  logic [2:0]         v_q;
  logic [ACC_W-1:0]   a_q, b_q;
  logic [ACC_W-1:0]   ahh_q, ahl_q, all_q, bhh_q, bhl_q, bll_q;
  logic [2*ACC_W-1:0] sa_q, sb_q;
  logic [2*ACC_W:0]   tot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= re_i[ACC_W-1] ? ACC_W'(-re_i) : ACC_W'(re_i);
    b_q <= im_i[ACC_W-1] ? ACC_W'(-im_i) : ACC_W'(im_i);
    ahh_q <= a_q[47:24] * a_q[47:24];
    ahl_q <= a_q[47:24] * a_q[23:0];
    all_q <= a_q[23:0] * a_q[23:0];
    bhh_q <= b_q[47:24] * b_q[47:24];
    bhl_q <= b_q[47:24] * b_q[23:0];
    bll_q <= b_q[23:0] * b_q[23:0];
    sa_q <= ({ahh_q, 48'd0}) + (96'(ahl_q) << 25) + 96'(all_q);
    sb_q <= ({bhh_q, 48'd0}) + (96'(bhl_q) << 25) + 96'(bll_q);
  end

  assign tot = 97'(sa_q) + 97'(sb_q);
  assign valid_o = v_q[2];
  assign power_o = (tot[96:95] != 2'b00) ? {PWR_W{1'b1}} : tot[94:32];

endmodule

// ===== rtl/core/cross_ambiguity_doppler_bank_top.sv =====
// Cross-ambiguity Doppler bank: per sample pair, each active bin rotates the reference
// by its oscillator, correlates with the conjugate scatter and saturates into a 48-bit
// accumulator held in one RAM. Each sample beat takes a single read-modify-write pass
// over the accumulator RAM across the effective bin count. On the window's last beat,
// each bin's power goes out in turn via dump, power and hold, held while stalled.
module cross_ambiguity_doppler_bank_top import cadb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [31:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SMP_W-1:0]  ref_re_i,
  input  logic signed [SMP_W-1:0]  ref_im_i,
  input  logic signed [SMP_W-1:0]  scat_re_i,
  input  logic signed [SMP_W-1:0]  scat_im_i,
  input  logic                     last_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [BIN_W-1:0]         bin_index_o,
  output logic [PWR_W-1:0]         power_o,
  output logic                     last_bin_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] nbins_q, nb_eff, iss_q;
  logic [PH_W-1:0]  minc_q, step_q, incr_q;
  logic [BIN_W-1:0] last_idx, k_q;
  logic signed [SMP_W-1:0] rr_q, ri_q, sr_q, si_q;
  logic last_q;
  logic [MAX_BINS-1:0] vld_q;
  logic issue, in_acc, rd_dump_q;
  logic [4:0] av_q;
  logic [BIN_W-1:0] t0_tag_q, s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;
  logic [PH_W-1:0] t0_incr_q, s1_ph_q, s2_ph_q, s3_ph_q, s4_ph_q;
  logic signed [ACC_W-1:0] s1_re_q, s1_im_q, s2_re_q, s2_im_q, s3_re_q, s3_im_q;
  logic signed [ACC_W-1:0] s4_re_q, s4_im_q;
  logic signed [SMP_W-1:0] s1_sin_q, s1_cos_q, xr_q, xi_q;
  logic signed [31:0] p_rc_q, p_is_q, p_rs_q, p_ic_q, q_rr_q, q_ii_q, q_ir_q, q_ri_q;
  logic [WORD_W-1:0] rdata, wdata;
  logic [BIN_W-1:0] raddr;
  logic ram_we;
  logic signed [ACC_W-1:0] m_re, m_im, m_re_d, m_im_d;
  logic [PH_W-1:0] m_ph;
  logic rd_vld;
  logic pwr_v;
  logic [PWR_W-1:0] pwr;
  logic [PWR_W-1:0] power_q;
  logic in_acc_q;

  assign nb_eff = (nbins_q == '0) ? CNT_W'(1) :
                  (nbins_q > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : nbins_q;
  assign last_idx = BIN_W'(nb_eff - CNT_W'(1));
  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign issue = (state_q == ST_ACC) && (iss_q < nb_eff);
  assign raddr = (state_q == ST_ACC) ? iss_q[BIN_W-1:0] : k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbins_q <= CNT_W'(31);
      minc_q <= '0;
      step_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_BINS:  nbins_q <= cfg_data_i[CNT_W-1:0];
        CFG_MIN_INCR:  minc_q <= cfg_data_i;
        CFG_INCR_STEP: step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ACC;
      ST_ACC: begin
        if (!issue && av_q == '0) state_d = last_q ? ST_DUMP : ST_IDLE;
      end
      ST_DUMP: state_d = ST_PWR;
      ST_PWR: if (pwr_v) state_d = ST_HOLD;
      ST_HOLD: begin
        if (!out_stall_i) state_d = (k_q == last_idx) ? ST_IDLE : ST_DUMP;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iss_q <= '0;
      av_q <= '0;
      k_q <= '0;
      vld_q <= '0;
      rd_dump_q <= 1'b0;
      in_acc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      in_acc_q <= in_acc;
      av_q <= {av_q[3:0], issue};
      rd_dump_q <= (state_q == ST_DUMP);
      if (in_acc) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + CNT_W'(1);
      end
      if (ram_we) begin
        vld_q[s4_tag_q] <= 1'b1;
      end
      if (state_q == ST_ACC && state_d == ST_DUMP) begin
        k_q <= '0;
      end else if (state_q == ST_HOLD && !out_stall_i) begin
        if (k_q == last_idx) begin
          vld_q <= '0;
        end else begin
          k_q <= k_q + BIN_W'(1);
        end
      end
    end
  end

  cadb_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BINS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s4_tag_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_vld = vld_q[av_q[0] ? t0_tag_q : k_q];
  assign m_re = rd_vld ? $signed(rdata[ACC_W-1:0]) : '0;
  assign m_im = rd_vld ? $signed(rdata[2*ACC_W-1:ACC_W]) : '0;
  assign m_ph = rd_vld ? rdata[WORD_W-1:2*ACC_W] : '0;

  assign m_re_d = sat_add48(s4_re_q, 33'(q_rr_q) + 33'(q_ii_q));
  assign m_im_d = sat_add48(s4_im_q, 33'(q_ir_q) - 33'(q_ri_q));
  assign ram_we = av_q[4];
  assign wdata = {s4_ph_q, m_im_d, m_re_d};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rr_q <= ref_re_i;
      ri_q <= ref_im_i;
      sr_q <= scat_re_i;
      si_q <= scat_im_i;
      last_q <= last_sample_i;
    end
    if (in_acc_q) begin
      incr_q <= minc_q + step_q;
    end else if (issue) begin
      incr_q <= incr_q + step_q;
    end
    t0_tag_q <= iss_q[BIN_W-1:0];
    t0_incr_q <= (nb_eff == CNT_W'(1)) ? '0 : (in_acc_q ? minc_q : incr_q);
    s1_tag_q <= t0_tag_q;
    s1_sin_q <= sine_lut(m_ph[PH_W-1 -: SIN_BITS]);
    s1_cos_q <= sine_lut(m_ph[PH_W-1 -: SIN_BITS] + SIN_BITS'(QUARTER));
    s1_re_q <= m_re;
    s1_im_q <= m_im;
    s1_ph_q <= m_ph + t0_incr_q;
    s2_tag_q <= s1_tag_q;
    s2_re_q <= s1_re_q;
    s2_im_q <= s1_im_q;
    s2_ph_q <= s1_ph_q;
    p_rc_q <= rr_q * s1_cos_q;
    p_is_q <= ri_q * s1_sin_q;
    p_rs_q <= rr_q * s1_sin_q;
    p_ic_q <= ri_q * s1_cos_q;
    s3_tag_q <= s2_tag_q;
    s3_re_q <= s2_re_q;
    s3_im_q <= s2_im_q;
    s3_ph_q <= s2_ph_q;
    xr_q <= rnd_sat16(34'(p_rc_q) - 34'(p_is_q));
    xi_q <= rnd_sat16(34'(p_rs_q) + 34'(p_ic_q));
    s4_tag_q <= s3_tag_q;
    s4_re_q <= s3_re_q;
    s4_im_q <= s3_im_q;
    s4_ph_q <= s3_ph_q;
    q_rr_q <= xr_q * sr_q;
    q_ii_q <= xi_q * si_q;
    q_ir_q <= xi_q * sr_q;
    q_ri_q <= xr_q * si_q;
    if (pwr_v) begin
      power_q <= pwr;
    end
  end

  cadb_pwr u_pwr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_dump_q),
    .re_i    (m_re),
    .im_i    (m_im),
    .valid_o (pwr_v),
    .power_o (pwr)
  );

  assign out_valid_o = (state_q == ST_HOLD);
  assign bin_index_o = k_q;
  assign power_o = power_q;
  assign last_bin_o = (k_q == last_idx);

  a_we_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_ACC) else $error("accumulator write outside sample pass");
  a_pwr_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pwr_v |-> state_q == ST_PWR) else $error("power result outside wait state");
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> av_q == '0 && !rd_dump_q) else $error("beat taken with pipeline busy");
  a_clear_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_bin_o) |=> vld_q == '0)
    else $error("bins not cleared at window end");

endmodule

// ===== tb/doppler_power_checker.sv =====
`timescale 1ns / 1ps
// Watches the register, sample and power channels of the Doppler bank and predicts
// every bin power beat. Depends on cadb_pkg for widths and register indexes.
module doppler_power_checker import cadb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [SMP_W-1:0] ref_re_i,
  input  logic signed [SMP_W-1:0] ref_im_i,
  input  logic signed [SMP_W-1:0] scat_re_i,
  input  logic signed [SMP_W-1:0] scat_im_i,
  input  logic                    last_sample_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [BIN_W-1:0]        bin_index_i,
  input  logic [PWR_W-1:0]        power_i,
  input  logic                    last_bin_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      powers_seen_o
);

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [PWR_W-1:0] power;
    logic             last;
  } bin_power_t;

  localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< 47);

  bin_power_t  power_due[$];
  logic [6:0]  bins_cfg;
  logic [31:0] base_incr;
  logic [31:0] incr_step;
  longint      acc_re [MAX_BINS];
  longint      acc_im [MAX_BINS];
  logic [31:0] osc_phase [MAX_BINS];
  longint      quarter_wave [QUARTER+1];

  function automatic longint quarter_sine(int k);
    longint unsigned t, t2, term;
    longint sum;
    t = (longint'(k) * 64'd1686629713) >> (SIN_BITS - 2);
    t2 = (t * t) >> 30;
    term = t;
    sum = longint'(t);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
      sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) / 32768;
    return (sum > 32767) ? 32767 : sum;
  endfunction

  function automatic longint osc_sine(logic [SIN_BITS-1:0] idx);
    int r;
    r = idx[SIN_BITS-3:0];
    if (idx[SIN_BITS-2]) r = QUARTER - r;
    return idx[SIN_BITS-1] ? -quarter_wave[r] : quarter_wave[r];
  endfunction

  function automatic longint round_q15(longint x);
    longint v;
    v = (x + 16384) >>> 15;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic longint clamp_acc(longint x);
    if (x > ACC_HI) return ACC_HI;
    if (x < ACC_LO) return ACC_LO;
    return x;
  endfunction

  function automatic int live_bins();
    if (bins_cfg == 0) return 1;
    if (bins_cfg > MAX_BINS) return MAX_BINS;
    return bins_cfg;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    errors_o++;
  endtask

  task automatic rotate_and_accumulate();
    int nb;
    longint c, s, xr, xi;
    logic [SIN_BITS-1:0] idx;
    logic [31:0] incr;
    logic [127:0] sq;
    logic [127:0] pw;
    bin_power_t bp;
    nb = live_bins();
    for (int d = 0; d < nb; d++) begin
      idx = osc_phase[d][31 -: SIN_BITS];
      s = osc_sine(idx);
      c = osc_sine(idx + SIN_BITS'(QUARTER));
      xr = round_q15(longint'(ref_re_i) * c - longint'(ref_im_i) * s);
      xi = round_q15(longint'(ref_re_i) * s + longint'(ref_im_i) * c);
      incr = (nb == 1) ? 32'd0 : base_incr + 32'(d) * incr_step;
      acc_re[d] = clamp_acc(acc_re[d] + xr * scat_re_i + xi * scat_im_i);
      acc_im[d] = clamp_acc(acc_im[d] + xi * scat_re_i - xr * scat_im_i);
      osc_phase[d] += incr;
    end
    if (!last_sample_i) return;
    for (int d = 0; d < nb; d++) begin
      sq = 128'(acc_re[d] < 0 ? -acc_re[d] : acc_re[d]);
      pw = sq * sq;
      sq = 128'(acc_im[d] < 0 ? -acc_im[d] : acc_im[d]);
      pw = (pw + sq * sq) >> 32;
      bp.bin = BIN_W'(d);
      bp.power = (pw > 128'h7fff_ffff_ffff_ffff) ? {PWR_W{1'b1}} : pw[PWR_W-1:0];
      bp.last = (d + 1 == nb);
      power_due.push_back(bp);
    end
    for (int d = 0; d < MAX_BINS; d++) begin
      acc_re[d] = 0;
      acc_im[d] = 0;
      osc_phase[d] = 0;
    end
  endtask

  initial begin
    for (int k = 0; k <= QUARTER; k++) quarter_wave[k] = quarter_sine(k);
    errors_o = 0;
    powers_seen_o = 0;
  end

  assign pending_o = power_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bin_power_t want;
    if (!rst_ni) begin
      bins_cfg = 7'd31;
      base_incr = 0;
      incr_step = 0;
      for (int d = 0; d < MAX_BINS; d++) begin
        acc_re[d] = 0;
        acc_im[d] = 0;
        osc_phase[d] = 0;
      end
      power_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NUM_BINS:  bins_cfg = cfg_data_i[6:0];
          CFG_MIN_INCR:  base_incr = cfg_data_i;
          CFG_INCR_STEP: incr_step = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        powers_seen_o++;
        if (power_due.size() == 0) begin
          report("unexpected beat, bin", 64'(bin_index_i), 64'd0);
        end else begin
          want = power_due.pop_front();
          if (bin_index_i !== want.bin) report("bin_index", 64'(bin_index_i), 64'(want.bin));
          if (power_i !== want.power) report("power", 64'(power_i), 64'(want.power));
          if (last_bin_i !== want.last) report("last_bin", 64'(last_bin_i), 64'(want.last));
        end
      end
      if (in_valid_i && !in_stall_i) rotate_and_accumulate();
    end
  end

endmodule

// ===== tb/tb_cross_ambiguity_doppler_bank_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the cross-ambiguity Doppler bank: register settings,
// sample windows with bursty input and stalling output. Depends on cadb_pkg, the checker and the top.
module tb_cross_ambiguity_doppler_bank_top;
  import cadb_pkg::*;

  localparam int HANG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = CFG_NUM_BINS;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SMP_W-1:0] ref_re_i = '0, ref_im_i = '0, scat_re_i = '0, scat_im_i = '0;
  logic last_sample_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [BIN_W-1:0] bin_index_o;
  logic [PWR_W-1:0] power_o;
  logic last_bin_o;

  int errors, pending, powers_seen;
  int samples_sent = 0, windows_sent = 0, burst_left = 0, idle_cycles = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  cross_ambiguity_doppler_bank_top dut (.*);

  doppler_power_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .ref_re_i, .ref_im_i, .scat_re_i, .scat_im_i,
    .last_sample_i, .out_valid_i(out_valid_o), .out_stall_i, .bin_index_i(bin_index_o),
    .power_i(power_o), .last_bin_i(last_bin_o), .errors_o(errors), .pending_o(pending),
    .powers_seen_o(powers_seen)
  );

  // receiver: stall pattern that changes mode every so often, plus one long hold
  always @(posedge clk_i) begin
    int mode;
    mode = ($time / 400) % 4;
    if (!hold_done && samples_sent >= 200) begin
      hold_done <= 1'b1;
      hold_cycles <= 600;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 5);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", HANG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic setup(logic [6:0] nb, logic [31:0] base, logic [31:0] step);
    drain();
    write_reg(CFG_NUM_BINS, 32'(nb));
    write_reg(CFG_MIN_INCR, base);
    write_reg(CFG_INCR_STEP, step);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [15:0] rr, logic [15:0] ri, logic [15:0] sr,
                             logic [15:0] si, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    ref_re_i <= rr;
    ref_im_i <= ri;
    scat_re_i <= sr;
    scat_im_i <= si;
    last_sample_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
    if (last) windows_sent++;
  endtask

  task automatic rand_window(int len);
    logic [15:0] v [4];
    for (int i = 0; i < len; i++) begin
      foreach (v[j]) begin
        case ($urandom_range(0, 7))
          0: v[j] = 16'h7fff;
          1: v[j] = 16'h8000;
          default: v[j] = 16'($urandom);
        endcase
      end
      send_sample(v[0], v[1], v[2], v[3], i == len - 1);
    end
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [6:0] nb;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // reset settings: 31 bins, zero increments
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b1);
    stop_input();
    setup(7'd1, 32'h4000_0000, 32'h1234_5678);
    send_sample(16'h7fff, 16'h0000, 16'h8000, 16'h0001, 1'b0);
    send_sample(16'h0000, 16'hffff, 16'h7fff, 16'h8000, 1'b1);
    stop_input();
    setup(7'd64, 32'h8000_0000, 32'hffff_ffff);
    rand_window(3);
    stop_input();
    setup(7'd0, 32'h7fff_ffff, 32'h0000_0001);
    rand_window(2);
    stop_input();
    setup(7'd127, 32'h0040_0000, 32'h0100_0000);
    rand_window(2);
    stop_input();
    setup(7'd2, 32'hffff_ffff, 32'h8000_0000);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    rand_window(4);
    stop_input();

    while (samples_sent < 430) begin
      case ($urandom_range(0, 9))
        0: nb = 7'd64;
        1: nb = 7'($urandom_range(0, 127));
        2: nb = 7'd1;
        default: nb = 7'($urandom_range(1, 12));
      endcase
      setup(nb, $urandom, $urandom);
      repeat ($urandom_range(2, 6)) rand_window($urandom_range(1, 8));
      // long window so the stall hold backs up the input
      if (!hold_done && samples_sent > 190) rand_window(40);
      stop_input();
    end

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d sample beats in %0d windows, %0d bin power beats checked.",
             samples_sent, windows_sent, powers_seen);
    $display("Bin counts 0 to 127, extreme phase steps, full-scale samples, long output hold.");
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cadb_pkg.sv
rtl/core/cadb_ram.sv
rtl/core/cadb_pwr.sv
rtl/core/cross_ambiguity_doppler_bank_top.sv
tb/doppler_power_checker.sv
tb/tb_cross_ambiguity_doppler_bank_top.sv
